FILE: rtl/hbw_pkg.sv
package hbw_pkg;

  localparam int unsigned HbWidth       = 5;
  localparam int unsigned DtWidth       = 10;
  localparam int unsigned LimitWidth    = 16;
  localparam int unsigned IdxOutWidth   = 3;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned InDataWidth   = 16;
  localparam int unsigned OutDataWidth  = 16;

  localparam int unsigned DefNModules   = 5;
  localparam int unsigned DefCountWidth = 16;

  localparam logic [LimitWidth-1:0] CrashLimitRst   = 16'd1000;
  localparam logic [HbWidth-1:0]    CriticalMaskRst = 5'd29;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgCrashLimit   = 2'd0,
    CfgCriticalMask = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic fail;
    logic crit_fail;
  } lane_stat_t;

  typedef struct packed {
    logic [IdxOutWidth-1:0] failed_index;
    logic                   critical_failure;
    logic                   shutdown_all;
    logic [HbWidth-1:0]     restart_mask;
  } res_t;

endpackage

FILE: rtl/hbw_lane.sv
module hbw_lane #(
  parameter int unsigned CountWidth = hbw_pkg::DefCountWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           hb_i,
  input  logic [hbw_pkg::DtWidth-1:0]    dt_i,
  input  logic [hbw_pkg::LimitWidth-1:0] limit_i,
  input  logic                           crit_i,
  input  logic                           go_i,
  output hbw_pkg::lane_stat_t            stat_o
);

  localparam int unsigned SumW =
      ((CountWidth > hbw_pkg::DtWidth) ? CountWidth : hbw_pkg::DtWidth) + 1;
  localparam int unsigned CmpW =
      (CountWidth > hbw_pkg::LimitWidth) ? CountWidth : hbw_pkg::LimitWidth;
  localparam logic [CountWidth-1:0] CntMax = {CountWidth{1'b1}};

  logic [CountWidth-1:0] cnt_q, cnt_d, cnt_sat;
  logic                  pend_q, pend_d;
  logic [SumW-1:0]       sum;
  logic                  pend_now;

  assign pend_now = pend_q | hb_i;
  assign sum      = SumW'(cnt_q) + SumW'(dt_i);
  assign cnt_sat  = (sum > SumW'(CntMax)) ? CntMax : sum[CountWidth-1:0];

  assign stat_o.fail      = !pend_now && (CmpW'(cnt_sat) > CmpW'(limit_i));
  assign stat_o.crit_fail = stat_o.fail && crit_i;

  always_comb begin
    cnt_d  = cnt_q;
    pend_d = pend_q;
    if (en_i) begin
      cnt_d  = (pend_now && go_i) ? '0 : cnt_sat;
      pend_d = pend_now && !go_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

endmodule

FILE: rtl/hbw_merge.sv
module hbw_merge #(
  parameter int unsigned NModules = hbw_pkg::DefNModules
) (
  input  hbw_pkg::lane_stat_t [NModules-1:0]   stat_i,
  output logic [NModules-1:0]                  go_o,
  output logic [hbw_pkg::HbWidth-1:0]          restart_o,
  output logic                                 found_o,
  output logic [hbw_pkg::IdxOutWidth-1:0]      fidx_o
);

  localparam int unsigned IdxW = (NModules > 1) ? $clog2(NModules) : 1;

  logic [IdxW-1:0] idx;

  always_comb begin
    go_o[0] = 1'b1;
    for (int i = 1; i < NModules; i++) begin
      go_o[i] = go_o[i-1] && !stat_i[i-1].crit_fail;
    end
  end

  always_comb begin
    found_o = 1'b0;
    idx     = '0;
    for (int i = NModules - 1; i >= 0; i--) begin
      if (stat_i[i].crit_fail) begin
        found_o = 1'b1;
        idx     = IdxW'(i);
      end
    end
  end

  assign fidx_o = hbw_pkg::IdxOutWidth'(idx);

  always_comb begin
    restart_o = '0;
    for (int i = 0; i < NModules && i < hbw_pkg::HbWidth; i++) begin
      restart_o[i] = stat_i[i].fail && !stat_i[i].crit_fail && go_o[i];
    end
  end

endmodule

FILE: rtl/heartbeat_watchdog_multi_top.sv
// Multi-channel heartbeat watchdog. Each poll request on the slave stream carries new heartbeat
// bits, the time elapsed since the previous poll and a stop flag; one result per poll leaves on
// the master stream. All module counters advance and are checked in parallel lanes, and a
// priority pick finds the first failed critical module, so a poll is accepted every cycle
// while the skid entry is empty. A two-entry output buffer keeps input flowing while a
// result waits. After shutdown latches, every poll reports shutdown only; reset clears it.
// Configuration writes (crash limit, critical mask) are always ready and should be made idle.
module heartbeat_watchdog_multi_top #(
  parameter int unsigned NModules   = hbw_pkg::DefNModules,
  parameter int unsigned CountWidth = hbw_pkg::DefCountWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // heartbeat_in[4:0], elapsed_time[14:5], stop_request[15]
  input  logic [hbw_pkg::InDataWidth-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // restart_mask[4:0], shutdown_all[5], critical_failure[6], failed_index[9:7], zero[15:10]
  output logic [hbw_pkg::OutDataWidth-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hbw_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [hbw_pkg::CfgDataWidth-1:0] cfg_data_i
);

  localparam int unsigned ResW = $bits(hbw_pkg::res_t);

  logic [hbw_pkg::LimitWidth-1:0] limit_q;
  logic [hbw_pkg::HbWidth-1:0]    cmask_q;
  logic                           shut_q, shut_d;

  logic [hbw_pkg::HbWidth-1:0]    hb;
  logic [hbw_pkg::DtWidth-1:0]    dt;
  logic                           stop;
  logic                           push, pop, lane_en;

  hbw_pkg::lane_stat_t [NModules-1:0] stat;
  logic [NModules-1:0]                go;
  logic [hbw_pkg::HbWidth-1:0]        restart;
  logic                               found;
  logic [hbw_pkg::IdxOutWidth-1:0]    fidx;

  hbw_pkg::res_t res_new, out_q, skid_q;
  logic          out_valid_q, skid_valid_q;

  assign hb   = s_axis_tdata[hbw_pkg::HbWidth-1:0];
  assign dt   = s_axis_tdata[hbw_pkg::HbWidth +: hbw_pkg::DtWidth];
  assign stop = s_axis_tdata[hbw_pkg::HbWidth + hbw_pkg::DtWidth];

  assign s_axis_tready = !skid_valid_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;
  assign lane_en       = push && !shut_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hbw_pkg::CrashLimitRst;
      cmask_q <= hbw_pkg::CriticalMaskRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hbw_pkg::CfgCrashLimit:   limit_q <= cfg_data_i[hbw_pkg::LimitWidth-1:0];
        hbw_pkg::CfgCriticalMask: cmask_q <= cfg_data_i[hbw_pkg::HbWidth-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NModules; i++) begin : g_lane
    logic hb_bit, crit_bit;
    if (i < hbw_pkg::HbWidth) begin : g_wired
      assign hb_bit   = hb[i];
      assign crit_bit = cmask_q[i];
    end else begin : g_unwired
      assign hb_bit   = 1'b0;
      assign crit_bit = 1'b0;
    end

    hbw_lane #(
      .CountWidth (CountWidth)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (lane_en),
      .hb_i    (hb_bit),
      .dt_i    (dt),
      .limit_i (limit_q),
      .crit_i  (crit_bit),
      .go_i    (go[i]),
      .stat_o  (stat[i])
    );
  end

  hbw_merge #(
    .NModules (NModules)
  ) u_merge (
    .stat_i    (stat),
    .go_o      (go),
    .restart_o (restart),
    .found_o   (found),
    .fidx_o    (fidx)
  );

  always_comb begin
    shut_d  = shut_q;
    res_new = '0;
    if (shut_q) begin
      res_new.shutdown_all = 1'b1;
    end else begin
      res_new.restart_mask     = restart;
      res_new.shutdown_all     = found || stop;
      res_new.critical_failure = found;
      res_new.failed_index     = found ? fidx : '0;
      if (push) begin
        shut_d = found || stop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shut_q <= 1'b0;
    end else begin
      shut_q <= shut_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res_new;
      end
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(hbw_pkg::OutDataWidth - ResW){1'b0}}, out_q};

endmodule

FILE: verif/tb.sv
module tb;
  import hbw_pkg::*;

  localparam int NMod = DefNModules;
  localparam int NRows = 19;
  localparam logic [CfgIdxWidth-1:0] CfgSpare = 2'd3;
  localparam res_t Quiet = '0;

  typedef enum logic {RowPoll, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CfgIdxWidth-1:0]  cidx;
    logic [CfgDataWidth-1:0] cdata;
    logic [HbWidth-1:0]      hb;
    logic [DtWidth-1:0]      dt;
    logic                    stop;
    logic                    known;
    res_t                    want;
  } step_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  logic [LimitWidth-1:0]   lim_reg = CrashLimitRst;
  logic [HbWidth-1:0]      crit_reg = CriticalMaskRst;
  logic [NMod-1:0]         pend_flags = '0;
  logic [DefCountWidth-1:0] elapsed [NMod];
  logic                    shut_lat = 1'b0;

  res_t      verdict_q [$];
  int        err_cnt = 0;
  int        s_idle_pct = 0;
  int        r_stall_pct = 0;
  step_row_t dir_rows [NRows];
  res_t      got_res;
  res_t      want_res;

  heartbeat_watchdog_multi_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < NMod; i++) elapsed[i] = '0;
  end

  function automatic res_t watchdog_poll(input logic [HbWidth-1:0] hb,
                                         input logic [DtWidth-1:0] dt, input logic stop);
    res_t r;
    logic [DefCountWidth:0] sum;
    bit hit;
    int i;
    r = '0;
    if (shut_lat) begin
      r.shutdown_all = 1'b1;
      return r;
    end
    pend_flags = pend_flags | hb[NMod-1:0];
    for (i = 0; i < NMod; i++) begin
      sum = {1'b0, elapsed[i]} + dt;
      elapsed[i] = sum[DefCountWidth] ? '1 : sum[DefCountWidth-1:0];
    end
    hit = 1'b0;
    for (i = 0; i < NMod && !hit; i++) begin
      if (pend_flags[i]) begin
        pend_flags[i] = 1'b0;
        elapsed[i] = '0;
      end else if (elapsed[i] > lim_reg) begin
        if (crit_reg[i]) begin
          shut_lat = 1'b1;
          r.critical_failure = 1'b1;
          r.failed_index = 3'(i);
          hit = 1'b1;
        end else begin
          r.restart_mask[i] = 1'b1;
        end
      end
    end
    if (stop) shut_lat = 1'b1;
    r.shutdown_all = shut_lat;
    return r;
  endfunction

  task automatic send_poll(input logic [HbWidth-1:0] hb, input logic [DtWidth-1:0] dt,
                           input logic stop, input logic known, input res_t want);
    res_t pred;
    while ($urandom_range(0, 99) < s_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {stop, dt, hb};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = watchdog_poll(hb, dt, stop);
    verdict_q.push_back(known ? want : pred);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (cfg_idx_e'(idx))
      CfgCrashLimit:   lim_reg = data[LimitWidth-1:0];
      CfgCriticalMask: crit_reg = data[HbWidth-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input bit guard, input int stop_pct);
    int rate [NMod];
    logic [HbWidth-1:0] hb;
    logic [DtWidth-1:0] dt;
    logic stop;
    logic [DefCountWidth:0] ahead;
    int pick;
    int i;
    int k;
    for (i = 0; i < NMod; i++) begin
      case ($urandom_range(0, 4))
        0, 1: rate[i] = 0;
        2: rate[i] = 10;
        3: rate[i] = 50;
        default: rate[i] = 90;
      endcase
    end
    for (k = 0; k < n_items; k++) begin
      hb = '0;
      for (i = 0; i < NMod; i++) hb[i] = ($urandom_range(0, 99) < rate[i]);
      pick = $urandom_range(0, 9);
      if (pick == 0) dt = '0;
      else if (pick < 5) dt = '1;
      else dt = DtWidth'($urandom_range(0, 1023));
      // keep critical modules alive until the closing phase
      if (guard) begin
        for (i = 0; i < NMod; i++) begin
          ahead = {1'b0, elapsed[i]} + dt;
          if (crit_reg[i] && !pend_flags[i] && !hb[i] && ahead > lim_reg) hb[i] = 1'b1;
        end
      end
      stop = ($urandom_range(0, 99) < stop_pct);
      send_poll(hb, dt, stop, 1'b0, Quiet);
    end
  endtask

  task automatic report(input string fld, input logic [15:0] want_v, input logic [15:0] got_v);
    if (err_cnt < 10)
      $display("mismatch %s: expected %h, got %h at %0t", fld, want_v, got_v, $realtime);
    err_cnt++;
  endtask

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= r_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = res_t'(m_axis_tdata[9:0]);
      if (verdict_q.size() == 0) begin
        report("unrequested result", 16'h0, m_axis_tdata);
      end else begin
        want_res = verdict_q.pop_front();
        if (got_res.restart_mask !== want_res.restart_mask)
          report("restart_mask", 16'(want_res.restart_mask), 16'(got_res.restart_mask));
        if (got_res.shutdown_all !== want_res.shutdown_all)
          report("shutdown_all", 16'(want_res.shutdown_all), 16'(got_res.shutdown_all));
        if (got_res.critical_failure !== want_res.critical_failure)
          report("critical_failure", 16'(want_res.critical_failure),
                 16'(got_res.critical_failure));
        if (got_res.failed_index !== want_res.failed_index)
          report("failed_index", 16'(want_res.failed_index), 16'(got_res.failed_index));
        if (m_axis_tdata[15:10] !== '0)
          report("padding", 16'h0, 16'(m_axis_tdata[15:10]));
      end
    end
  end

  initial begin
    int r;
    int ph;
    int mode;
    logic [LimitWidth-1:0] lim;
    logic [HbWidth-1:0] msk;
    dir_rows = '{
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h00, 10'd0, 1'b0, 1'b1, Quiet},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h1F, 10'd1023, 1'b0, 1'b1, Quiet},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h1D, 10'd1023, 1'b0, 1'b1,
        '{3'd0, 1'b0, 1'b0, 5'h02}},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h1D, 10'd0, 1'b0, 1'b1,
        '{3'd0, 1'b0, 1'b0, 5'h02}},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h1F, 10'd1023, 1'b0, 1'b1, Quiet},
      '{RowCfg, CfgCrashLimit, 16'h0000, 5'h00, 10'd0, 1'b0, 1'b0, Quiet},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h00, 10'd0, 1'b0, 1'b1, Quiet},
      '{RowCfg, CfgCriticalMask, 16'h0000, 5'h00, 10'd0, 1'b0, 1'b0, Quiet},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h00, 10'd1, 1'b0, 1'b1,
        '{3'd0, 1'b0, 1'b0, 5'h1F}},
      '{RowCfg, CfgCrashLimit, 16'hFFFF, 5'h00, 10'd0, 1'b0, 1'b0, Quiet},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h0A, 10'd1023, 1'b0, 1'b0, Quiet},
      '{RowCfg, CfgCriticalMask, 16'hFFFF, 5'h00, 10'd0, 1'b0, 1'b0, Quiet},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h15, 10'd512, 1'b0, 1'b0, Quiet},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h00, 10'd1023, 1'b0, 1'b0, Quiet},
      '{RowCfg, CfgSpare, 16'hA5A5, 5'h00, 10'd0, 1'b0, 1'b0, Quiet},
      '{RowCfg, CfgCrashLimit, 16'd1000, 5'h00, 10'd0, 1'b0, 1'b0, Quiet},
      '{RowCfg, CfgCriticalMask, 16'hFFFD, 5'h00, 10'd0, 1'b0, 1'b0, Quiet},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h1F, 10'd1023, 1'b0, 1'b1, Quiet},
      '{RowPoll, CfgCrashLimit, 16'h0000, 5'h02, 10'd0, 1'b0, 1'b0, Quiet}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NRows; r++) begin
      if (dir_rows[r].kind == RowCfg) begin
        drain();
        write_reg(dir_rows[r].cidx, dir_rows[r].cdata);
      end else begin
        send_poll(dir_rows[r].hb, dir_rows[r].dt, dir_rows[r].stop, dir_rows[r].known,
                  dir_rows[r].want);
      end
    end

    for (ph = 0; ph < 9; ph++) begin
      drain();
      mode = (ph == 8) ? $urandom_range(0, 3) : ph % 4;
      case (mode)
        0: begin s_idle_pct = 0;  r_stall_pct = 0;  end
        1: begin s_idle_pct = 69; r_stall_pct = 0;  end
        2: begin s_idle_pct = 0;  r_stall_pct = 69; end
        default: begin s_idle_pct = 38; r_stall_pct = 38; end
      endcase
      case (ph)
        0: begin lim = '1; msk = '1; end
        1: begin lim = '0; msk = '0; end
        3: begin lim = LimitWidth'($urandom_range(500, 3000)); msk = '0; end
        4: begin lim = '1; msk = '0; end
        5: begin lim = 16'hFFFE; msk = HbWidth'($urandom); end
        7: begin lim = LimitWidth'($urandom_range(0, 2000)); msk = HbWidth'($urandom); end
        8: begin
          lim = LimitWidth'($urandom_range(0, 3000));
          msk = HbWidth'($urandom_range(1, 31));
        end
        default: begin lim = LimitWidth'($urandom); msk = HbWidth'($urandom); end
      endcase
      write_reg(CfgCrashLimit, lim);
      write_reg(CfgCriticalMask, {11'($urandom), msk});
      if (ph == 8) run_phase(60, 1'b0, 25);
      else run_phase(110, 1'b1, 0);
    end

    drain();
    s_idle_pct = 0;
    r_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $display("%0d results never arrived", verdict_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("** heartbeat_watchdog_multi_top: PASSED **");
    end else begin
      $display("** heartbeat_watchdog_multi_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("** heartbeat_watchdog_multi_top: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
rtl/hbw_pkg.sv
rtl/hbw_lane.sv
rtl/hbw_merge.sv
rtl/heartbeat_watchdog_multi_top.sv
verif/tb.sv
